// ===== src/utf8d_pkg.sv =====
// Package for the UTF-8 decoder: item and result types, the record passed from
// the front end to the back end, and byte classification functions.
// No dependencies.
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

	// Sequence lengths implied by a lead byte.
	localparam logic [2:0] LEN_BAD  = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  byte_count;
		logic        invalid;
		logic        run_last;
	} out_item_t;

	// One request from the front end: rep_n replacement results come first,
	// then the final result, which carries run_last.
	typedef struct packed {
		logic [1:0]  rep_n;
		logic [20:0] code_point;
		logic [2:0]  byte_count;
		logic        invalid;
	} action_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_BAD;
		if (b < 8'h80) len = LEN_ONE;
		else if (b >= 8'hC2 && b <= 8'hDF) len = LEN_TWO;
		else if (b >= 8'hE0 && b <= 8'hEF) len = LEN_THREE;
		else if (b >= 8'hF0 && b <= 8'hF4) len = LEN_FOUR;
		return len;
	endfunction

	function automatic logic cont_byte(input logic [7:0] b);
		return (b & 8'hC0) == 8'h80;
	endfunction

	// Range check on the second byte against overlong forms, surrogates
	// and values above the Unicode range.
	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		ok = cont_byte(b);
		if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
		if (lead == 8'hED && b >= 8'hA0) ok = 1'b0;
		if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
		if (lead == 8'hF4 && b >= 8'h90) ok = 1'b0;
		return ok;
	endfunction

endpackage

// ===== src/utf8d_front.sv =====
// Front end of the UTF-8 decoder: holds an unfinished sequence, classifies
// each byte and issues one request per byte that yields results.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  utf8d_pkg::in_item_t item,
	output logic               act_valid,
	output utf8d_pkg::action_t act
);
	import utf8d_pkg::*;

	logic [7:0] held_q [3];
	logic [1:0] held_count_q;
	logic [2:0] expected_length_q;

	logic [7:0]  b;
	logic        eos;
	logic [2:0]  lb;
	logic        ok;
	logic        done;
	logic [20:0] cp;
	logic [1:0]  count_d;
	logic [2:0]  exp_d;
	logic        wr_en;
	logic [1:0]  wr_idx;

	assign b   = item.in_byte;
	assign eos = item.end_of_string;
	assign lb  = lead_len(b);
	assign ok  = (held_count_q == 2'd1) ? second_ok(held_q[0], b) : cont_byte(b);
	assign done = ({1'b0, held_count_q} + 3'd1) == expected_length_q;

	// Assemble the scalar value from the held bytes and the incoming byte.
	always_comb begin
		unique case (expected_length_q)
			LEN_TWO:   cp = {10'd0, held_q[0][4:0], b[5:0]};
			LEN_THREE: cp = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
			LEN_FOUR:  cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
			default:   cp = '0;
		endcase
	end

	// Classification and next state of the held sequence.
	always_comb begin
		act_valid      = 1'b0;
		act.rep_n      = 2'd0;
		act.code_point = REPLACEMENT;
		act.byte_count = 3'd1;
		act.invalid    = 1'b1;
		count_d        = 2'd0;
		exp_d          = 3'd0;
		wr_en          = 1'b0;
		wr_idx         = 2'd0;
		if (held_count_q == 2'd0 || !ok) begin
			// The byte starts a new sequence; a broken held one yields a
			// replacement for each held byte first.
			act.rep_n = held_count_q;
			if (lb == LEN_ONE) begin
				act_valid      = 1'b1;
				act.code_point = {13'd0, b};
				act.invalid    = 1'b0;
			end else if (lb == LEN_BAD || eos) begin
				act_valid = 1'b1;
			end else begin
				// Valid lead held; any replacements owed still go out.
				act_valid = held_count_q != 2'd0;
				act.rep_n = held_count_q - 2'd1;
				count_d   = 2'd1;
				exp_d     = lb;
				wr_en     = 1'b1;
				wr_idx    = 2'd0;
			end
		end else if (done) begin
			act_valid      = 1'b1;
			act.code_point = cp;
			act.byte_count = expected_length_q;
			act.invalid    = 1'b0;
		end else if (eos) begin
			// Truncated by the end of the string: every byte is a replacement.
			act_valid = 1'b1;
			act.rep_n = held_count_q;
		end else begin
			count_d = held_count_q + 2'd1;
			exp_d   = expected_length_q;
			wr_en   = 1'b1;
			wr_idx  = held_count_q;
		end
	end

	// Held sequence control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q      <= 2'd0;
			expected_length_q <= 3'd0;
		end else if (fire) begin
			held_count_q      <= count_d;
			expected_length_q <= exp_d;
		end
	end

	// Held bytes need no reset.
	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			if (wr_idx == 2'd0) held_q[0] <= b;
			if (wr_idx == 2'd1) held_q[1] <= b;
			if (wr_idx == 2'd2) held_q[2] <= b;
		end
	end

endmodule

// ===== src/utf8d_queue.sv =====
// Short request queue between the decoder front end and back end.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_queue #(
	parameter int unsigned DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  utf8d_pkg::action_t wr_data,
	input  logic               rd,
	output utf8d_pkg::action_t rd_data,
	output logic               full,
	output logic               empty
);
	import utf8d_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	action_t        mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== src/utf8d_back.sv =====
// Back end of the UTF-8 decoder: expands each request into its results and
// holds the current result in an output register.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

module utf8d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  utf8d_pkg::action_t   q_data,
	output logic                 q_rd,
	output logic                 empty,
	input  logic                 pop,
	output utf8d_pkg::out_item_t result
);
	import utf8d_pkg::*;

	action_t cur_q;
	logic    cur_valid_q;
	logic    take;
	logic    load;

	assign take  = pop && cur_valid_q;
	assign load  = !cur_valid_q || (take && cur_q.rep_n == 2'd0);
	assign q_rd  = load && !q_empty;
	assign empty = !cur_valid_q;

	// Replacements go out first; the final result closes the request.
	always_comb begin
		if (cur_q.rep_n != 2'd0) begin
			result.code_point = REPLACEMENT;
			result.byte_count = 3'd1;
			result.invalid    = 1'b1;
			result.run_last   = 1'b0;
		end else begin
			result.code_point = cur_q.code_point;
			result.byte_count = cur_q.byte_count;
			result.invalid    = cur_q.invalid;
			result.run_last   = 1'b1;
		end
	end

	// Output request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
		end else if (load) begin
			cur_valid_q <= !q_empty;
			cur_q       <= q_data;
		end else if (take) begin
			cur_q.rep_n <= cur_q.rep_n - 2'd1;
		end
	end

endmodule

// ===== src/utf8_decoder_top.sv =====
// Top level of the streaming UTF-8 decoder.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
//
// Usage: bytes of a string enter through a queue-style port (push/full),
// one per accepted cycle, with end_of_string set on the final byte. Decoded
// code points leave through a queue-style port (empty/pop); the oldest
// result is shown while empty is low.
// A byte that completes a code point reaches the output through the request
// queue, then the output register.
// Throughput: one byte per cycle while each byte yields at most one
// result and the receiver pops it. A malformed sequence yields one
// replacement for each held byte, lead included, so one byte can yield
// up to four results, expanded one per cycle while the receiver pops.
// Reset clears the held sequence, the request queue and the output
// register. When the receiver stalls, results wait in the output register
// and the queue; full rises once the queue holds QUEUE_DEPTH requests.
`timescale 1ns / 1ps

module utf8_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  utf8d_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output utf8d_pkg::out_item_t result
);
	import utf8d_pkg::*;

	logic    fire;
	logic    act_valid;
	action_t act;
	logic    q_rd;
	logic    q_empty;
	action_t q_data;

	assign fire = push && !full;

	// Byte classification and held sequence.
	utf8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item),
		.act_valid (act_valid),
		.act       (act)
	);

	// Request queue between the two sides.
	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fire && act_valid),
		.wr_data (act),
		.rd      (q_rd),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	// Result expansion and output register.
	utf8d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== tb/sv/utf8_decoder_checker.sv =====
// Checker for the UTF-8 decoder: predicts the decoded code points of every
// accepted byte request and compares them with the accepted result requests.
// Depends on utf8d_pkg for the request and result types.
`timescale 1ns / 1ps

module utf8_decoder_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  utf8d_pkg::in_item_t  item,
	input  logic                 empty,
	input  logic                 pop,
	input  utf8d_pkg::out_item_t result,
	output int                   mismatches,
	output int                   pending
);
	import utf8d_pkg::*;

	// Decoder state: bytes of a well-formed but unfinished sequence.
	logic [7:0]  held [0:2];
	int unsigned held_n;

	// Code points predicted but not yet seen on the result side, oldest first.
	out_item_t   code_points_due [$];
	out_item_t   want;

	initial mismatches = 0;

	// Length of the sequence that a byte starts; zero when it cannot lead.
	function automatic int unsigned span_of(input logic [7:0] b);
		if (b <= 8'h7F) return 1;
		if (b >= 8'hC2 && b <= 8'hDF) return 2;
		if (b >= 8'hE0 && b <= 8'hEF) return 3;
		if (b >= 8'hF0 && b <= 8'hF4) return 4;
		return 0;
	endfunction

	function automatic logic is_tail(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// The second byte also rules out overlong forms, surrogates and values
	// above the Unicode range.
	function automatic logic second_fits(input logic [7:0] lead, input logic [7:0] b);
		if (!is_tail(b)) return 1'b0;
		if (lead == 8'hE0 && b < 8'hA0) return 1'b0;
		if (lead == 8'hED && b >= 8'hA0) return 1'b0;
		if (lead == 8'hF0 && b < 8'h90) return 1'b0;
		if (lead == 8'hF4 && b >= 8'h90) return 1'b0;
		return 1'b1;
	endfunction

	// Decode the held bytes plus one new byte; append every code point that
	// this byte releases and keep any unfinished prefix.
	function automatic void decode_byte(input in_item_t req);
		logic [7:0]  pend [$];
		out_item_t   r;
		int unsigned need, have, take, released;
		logic        ok;
		logic        stop;

		for (int i = 0; i < held_n; i++) pend.push_back(held[i]);
		pend.push_back(req.in_byte);
		released = 0;
		stop = 1'b0;
		while (pend.size() > 0 && !stop) begin
			need = span_of(pend[0]);
			take = 1;
			r.code_point = REPLACEMENT;
			r.byte_count = 3'd1;
			r.invalid = 1'b1;
			r.run_last = 1'b0;
			if (need == 1) begin
				r.code_point = {13'd0, pend[0]};
				r.invalid = 1'b0;
			end else if (need != 0) begin
				have = (pend.size() < need) ? pend.size() : need;
				ok = 1'b1;
				for (int i = 1; i < have; i++) begin
					if (i == 1 ? !second_fits(pend[0], pend[1]) : !is_tail(pend[i])) ok = 1'b0;
				end
				if (ok && pend.size() >= need) begin
					case (need)
						2: r.code_point = {10'd0, pend[0][4:0], pend[1][5:0]};
						3: r.code_point = {5'd0, pend[0][3:0], pend[1][5:0], pend[2][5:0]};
						default: r.code_point = {pend[0][2:0], pend[1][5:0], pend[2][5:0],
							pend[3][5:0]};
					endcase
					r.byte_count = need[2:0];
					r.invalid = 1'b0;
					take = need;
				end else if (ok && !req.end_of_string) begin
					// A valid prefix waits for more bytes.
					stop = 1'b1;
				end
			end
			if (!stop) begin
				code_points_due.push_back(r);
				released++;
				repeat (take) void'(pend.pop_front());
			end
		end

		held_n = pend.size();
		for (int i = 0; i < held_n; i++) held[i] = pend[i];
		if (released > 0) code_points_due[code_points_due.size() - 1].run_last = 1'b1;
	endfunction

	function automatic void report(input string what, input logic [20:0] exp_v,
		input logic [20:0] act_v);
		$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
		mismatches++;
	endfunction

	// Results are compared before the byte request of the same edge is
	// decoded, since a result never leaves in the cycle its byte enters.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_points_due.delete();
			held_n = 0;
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (code_points_due.size() == 0) begin
					$display("%0t: result expected none, actual code point 0x%0h",
						$time, result.code_point);
					mismatches++;
				end else begin
					want = code_points_due.pop_front();
					if (result.code_point !== want.code_point)
						report("code_point", want.code_point, result.code_point);
					if (result.byte_count !== want.byte_count)
						report("byte_count", {18'd0, want.byte_count},
							{18'd0, result.byte_count});
					if (result.invalid !== want.invalid)
						report("invalid", {20'd0, want.invalid}, {20'd0, result.invalid});
					if (result.run_last !== want.run_last)
						report("run_last", {20'd0, want.run_last}, {20'd0, result.run_last});
				end
			end
			if (push && !full) decode_byte(item);
			pending <= code_points_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and the
// result receiver, with the verdict at the end.
// Depends on utf8d_pkg, utf8_decoder_top and utf8_decoder_checker.
`timescale 1ns / 1ps

module testbench;
	import utf8d_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 170;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT  = 100000;

	// Directed bytes: bit 8 is the end-of-string flag.
	localparam logic [8:0] DIRECTED [27] = '{
		9'h000, 9'h07F,                 // smallest and largest single byte
		9'h0C2, 9'h080,                 // smallest two-byte form
		9'h0E0, 9'h0A0, 9'h080,         // smallest three-byte form
		9'h0E0, 9'h09F,                 // overlong three-byte form
		9'h0ED, 9'h0A0,                 // surrogate
		9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, // largest scalar value
		9'h0F4, 9'h090,                 // above the Unicode range
		9'h0F0, 9'h08F,                 // overlong four-byte form
		9'h0F0, 9'h090, 9'h080, 9'h041, // wrong continuation after three held bytes
		9'h0E2, 9'h182,                 // sequence cut short by the string end
		9'h0C1, 9'h1FF                  // bad lead bytes
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	int          mismatches;
	int          pending;
	int unsigned cycle_count;

	// Bytes of the string being built.
	logic [7:0] str_q [$];

	// Pacing of the sender and the receiver; the hold-off flags are shared.
	logic tx_fast = 1'b0;
	logic rx_fast = 1'b0;
	logic hold_req = 1'b0;
	logic holding = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	utf8_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	utf8_decoder_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Offer one byte request and hold it until it is taken. Push stays high
	// afterwards so that a back-to-back request needs no second drive.
	task automatic send_byte(input logic [7:0] value, input logic last);
		int unsigned gap;
		logic        taken;

		gap = (tx_fast || holding) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{in_byte: value, end_of_string: last};
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	// Stop offering and wait until every predicted code point has come out.
	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic logic [20:0] draw_scalar(input int unsigned len);
		case (len)
			1: return 21'($urandom_range(0, 'h7F));
			2: return 21'($urandom_range('h80, 'h7FF));
			3: return $urandom_range(0, 1) ? 21'($urandom_range('h800, 'hD7FF))
				: 21'($urandom_range('hE000, 'hFFFF));
			default: return 21'($urandom_range('h10000, 'h10FFFF));
		endcase
	endfunction

	function automatic void add_encoded(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: str_q.push_back({1'b0, cp[6:0]});
			2: begin
				str_q.push_back({3'b110, cp[10:6]});
				str_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_q.push_back({4'b1110, cp[15:12]});
				str_q.push_back({2'b10, cp[11:6]});
				str_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_q.push_back({5'b11110, cp[20:18]});
				str_q.push_back({2'b10, cp[17:12]});
				str_q.push_back({2'b10, cp[11:6]});
				str_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic logic [7:0] tail_byte();
		return 8'($urandom_range('h80, 'hBF));
	endfunction

	// Append one piece of a string: mostly valid scalars, the rest bad leads,
	// cut-short sequences, wrong continuations and out-of-range forms.
	function automatic void add_unit();
		int unsigned kind, len, first;

		kind = $urandom_range(0, 9);
		len = $urandom_range(2, 4);
		first = str_q.size();
		if (kind <= 5) begin
			len = $urandom_range(1, 4);
			add_encoded(draw_scalar(len), len);
		end else if (kind == 6) begin
			str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
				: 8'($urandom_range('hF5, 'hFF)));
		end else if (kind == 7) begin
			add_encoded(draw_scalar(len), len);
			repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
		end else if (kind == 8) begin
			add_encoded(draw_scalar(len), len);
			str_q[first + $urandom_range(1, len - 1)] = $urandom_range(0, 1)
				? 8'($urandom_range(0, 'h7F)) : 8'($urandom_range('hC0, 'hFF));
		end else begin
			case ($urandom_range(0, 4))
				0: begin
					str_q.push_back(8'hE0);
					str_q.push_back(8'($urandom_range('h80, 'h9F)));
					str_q.push_back(tail_byte());
				end
				1: begin
					str_q.push_back(8'hED);
					str_q.push_back(8'($urandom_range('hA0, 'hBF)));
					str_q.push_back(tail_byte());
				end
				2: begin
					str_q.push_back(8'hF0);
					str_q.push_back(8'($urandom_range('h80, 'h8F)));
					str_q.push_back(tail_byte());
					str_q.push_back(tail_byte());
				end
				3: begin
					str_q.push_back(8'hF4);
					str_q.push_back(8'($urandom_range('h90, 'hBF)));
					str_q.push_back(tail_byte());
					str_q.push_back(tail_byte());
				end
				default: begin
					str_q.push_back(8'($urandom_range('hC0, 'hC1)));
					str_q.push_back(tail_byte());
				end
			endcase
		end
	endfunction

	// Byte stimulus: reset, directed bytes, then random strings.
	initial begin : stimulus
		int unsigned sent;
		logic        noisy;
		logic        paused;
		logic        hold_asked;

		sent = 0;
		paused = 1'b0;
		hold_asked = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		wait_drained();

		while (sent < RANDOM_ITEMS) begin
			tx_fast = ($urandom_range(0, 3) == 0);
			if (!hold_asked && sent >= 40) begin
				hold_asked = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && sent >= 120) begin
				paused = 1'b1;
				wait_drained();
			end
			// Noise strings carry random bytes and random end flags.
			noisy = ($urandom_range(0, 6) == 0);
			if (noisy) begin
				repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6)) add_unit();
			end
			for (int i = 0; i < str_q.size(); i++) begin
				send_byte(str_q[i], noisy ? 1'($urandom_range(0, 1)) : (i == str_q.size() - 1));
			end
			sent += str_q.size();
			str_q.delete();
		end

		push <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result receiver: random stalls, fast stretches and one long hold-off
	// that lets the decoder fill up and stall its byte requests.
	initial begin : receiver
		int unsigned stall, popped;
		logic        got;

		popped = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (popped % 20 == 0) rx_fast = ($urandom_range(0, 3) == 0);
			if (hold_req) begin
				hold_req = 1'b0;
				holding = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end
			stall = rx_fast ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				got = !empty;
				@(posedge clk);
			end while (!got);
			popped++;
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
src/utf8d_pkg.sv
src/utf8d_front.sv
src/utf8d_queue.sv
src/utf8d_back.sv
src/utf8_decoder_top.sv
tb/sv/utf8_decoder_checker.sv
tb/sv/testbench.sv
